// ===== rtl/sltev_pkg.sv =====
// Types, codes and byte classification shared by the script lexer event unit.
`timescale 1ns / 1ps

package sltev_pkg;

	// Byte classes. The codes are stored in the previous-class register.
	typedef enum logic [3:0] {
		CL_NULL   = 4'd0,
		CL_OTHER  = 4'd1,
		CL_LETTER = 4'd2,
		CL_DIGIT  = 4'd3,
		CL_DQ     = 4'd4,
		CL_SQ     = 4'd5,
		CL_JOIN   = 4'd6,
		CL_PUNCT  = 4'd7,
		CL_SPACE  = 4'd8,
		CL_BSL    = 4'd9,
		CL_NL     = 4'd10,
		CL_SEMI   = 4'd11
	} class_t;

	// Scan mode, one-hot.
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'b001,
		MODE_STRING  = 3'b010,
		MODE_COMMENT = 3'b100
	} mode_t;

	// Event codes.
	localparam logic [2:0] EV_APPEND = 3'd0;
	localparam logic [2:0] EV_EMIT   = 3'd1;
	localparam logic [2:0] EV_DROP   = 3'd2;
	localparam logic [2:0] EV_SINGLE = 3'd3;
	localparam logic [2:0] EV_END    = 3'd4;

	// Token types.
	localparam logic [3:0] TT_WORD     = 4'd0;
	localparam logic [3:0] TT_DEC      = 4'd1;
	localparam logic [3:0] TT_BIN      = 4'd2;
	localparam logic [3:0] TT_HEX      = 4'd3;
	localparam logic [3:0] TT_OPERATOR = 4'd4;
	localparam logic [3:0] TT_BREAKER  = 4'd5;
	localparam logic [3:0] TT_PUNCT    = 4'd6;
	localparam logic [3:0] TT_SQ_STR   = 4'd7;
	localparam logic [3:0] TT_DQ_STR   = 4'd8;

	// Number radix codes.
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_BIN = 2'd1;
	localparam logic [1:0] RADIX_HEX = 2'd2;

	// Characters with a special role.
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// One result entry.
	typedef struct packed {
		logic [2:0] ev;
		logic [7:0] data;
		logic [3:0] ttype;
	} res_t;

	function automatic class_t classify(input logic [7:0] c);
		class_t cl;
		cl = CL_OTHER;
		if (c == 8'h00 || c == 8'hFF)
			cl = CL_NULL;
		else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
			cl = CL_LETTER;
		else if (c >= CH_ZERO && c <= 8'h39)
			cl = CL_DIGIT;
		else if (c == 8'h22)
			cl = CL_DQ;
		else if (c == 8'h27)
			cl = CL_SQ;
		else if (c == CH_STAR || c == CH_SLASH || c == 8'h2B || c == 8'h3D ||
			c == 8'h5E || c == 8'h3C || c == 8'h3E || c == CH_DOT)
			cl = CL_JOIN;
		else if (c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h7B ||
			c == 8'h7D || c == 8'h2D || c == 8'h2C || c == 8'h3A || c == 8'h40)
			cl = CL_PUNCT;
		else if (c == 8'h20 || c == 8'h09)
			cl = CL_SPACE;
		else if (c == CH_BSL)
			cl = CL_BSL;
		else if (c == CH_NL)
			cl = CL_NL;
		else if (c == CH_SEMI)
			cl = CL_SEMI;
		return cl;
	endfunction

	function automatic logic is_hex_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

endpackage

// ===== rtl/script_lexer_token_events_unit.sv =====
// Top level of the per-byte script lexer that turns source bytes into token events.
`timescale 1ns / 1ps

// How to use this block:
// Source bytes enter one per beat on the s_axis channel (tdata is the byte).
// Every byte produces zero to three result beats on the m_axis channel: an
// event code and token type in tuser, the byte in tdata, and tlast on the
// final beat caused by that source byte. Bytes that produce nothing (spaces,
// unknown bytes, bytes inside a comment) simply disappear.
// A byte is first captured in an input register. From there the lexer
// logic classifies it against the scan state and, once the result buffer
// is free, writes its whole result list into that three-entry buffer, from
// which the result beats are offered. The buffer is loaded while its last
// entry is being taken, so while the receiver keeps tready high a stream of
// single-result bytes runs at one byte per cycle; a byte with more than one
// result occupies the output until all its beats are taken, and that buffer
// drain is what sets the rate. When the receiver stalls, the buffer holds,
// then the input register fills and s_axis_tready drops; nothing is lost.
// Reset clears the scan state, the buffer and the end byte register (end
// byte 0). The end byte is written through cfg_we/cfg_wdata, by the user
// only while the block is idle; the block itself does not enforce this.
module script_lexer_token_events_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] byte_out
	output logic [6:0] m_axis_tuser,   // [2:0] event_res, [6:3] token_type
	output logic       m_axis_tlast    // last
);
	import sltev_pkg::*;

	// Configuration.
	logic [7:0] end_byte_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Scan state.
	mode_t      mode_q;
	logic [7:0] prev_byte_q;
	class_t     prev_class_q;
	logic [1:0] pend_cnt_q;
	logic       quote_single_q;
	logic [1:0] radix_q;
	logic       dot_seen_q;
	logic       block_cmt_q;
	logic       started_q;

	// Result buffer: entries, number of entries and read index.
	res_t       res_q [3];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;

	// Lexer logic outputs.
	res_t       res_c [3];
	logic [1:0] n_c;
	mode_t      nx_mode;
	logic [7:0] nx_prev_byte;
	class_t     nx_prev_class;
	logic [1:0] nx_pend_cnt;
	logic       nx_quote_single;
	logic [1:0] nx_radix;
	logic       nx_dot_seen;
	logic       nx_block_cmt;
	logic       nx_started;

	logic       take;
	logic       buf_free;
	logic       load;
	res_t       out_res;

	class_t     cl;
	class_t     ecl;
	logic       keep;
	logic       early;

	assign take     = m_axis_tvalid && m_axis_tready;
	assign buf_free = (cnt_q == 2'd0) || ((idx_q + 2'd1 == cnt_q) && m_axis_tready);
	assign load     = valid_s1 && buf_free;
	assign s_axis_tready = !valid_s1 || buf_free;

	// Lexer step for the byte in the input register.
	always_comb begin
		res_c[0] = '0;
		res_c[1] = '0;
		res_c[2] = '0;
		n_c = 2'd0;
		nx_mode = mode_q;
		nx_prev_byte = prev_byte_q;
		nx_prev_class = prev_class_q;
		nx_pend_cnt = pend_cnt_q;
		nx_quote_single = quote_single_q;
		nx_radix = radix_q;
		nx_dot_seen = dot_seen_q;
		nx_block_cmt = block_cmt_q;
		nx_started = started_q;
		early = 1'b0;
		keep = 1'b0;
		cl = classify(byte_s1);
		ecl = cl;

		unique case (mode_q)
			MODE_STRING: begin
				if ((cl == CL_DQ && !quote_single_q) || (cl == CL_SQ && quote_single_q)) begin
					res_c[n_c] = '{ev: EV_EMIT, data: 8'd0,
						ttype: quote_single_q ? TT_SQ_STR : TT_DQ_STR};
					n_c = n_c + 2'd1;
					nx_mode = MODE_NORMAL;
					nx_pend_cnt = 2'd0;
					nx_quote_single = 1'b0;
				end else if (cl == CL_DQ || cl == CL_SQ || cl == CL_LETTER || cl == CL_DIGIT ||
					cl == CL_JOIN || cl == CL_PUNCT || cl == CL_SPACE) begin
					if (nx_pend_cnt != 2'd2) nx_pend_cnt = nx_pend_cnt + 2'd1;
					res_c[n_c] = '{ev: EV_APPEND, data: byte_s1, ttype: TT_WORD};
					n_c = n_c + 2'd1;
				end
			end
			MODE_COMMENT: begin
				if ((byte_s1 == CH_NL && !block_cmt_q) ||
					(prev_byte_q == CH_STAR && byte_s1 == CH_SLASH && block_cmt_q)) begin
					nx_mode = MODE_NORMAL;
					nx_block_cmt = 1'b0;
				end
			end
			MODE_NORMAL: begin
				// Token boundary, with the number continuations kept together.
				if (started_q) begin
					keep = (prev_class_q == CL_JOIN && prev_byte_q == CH_DOT &&
							pend_cnt_q == 2'd1 && cl == CL_DIGIT && !dot_seen_q) ||
						(prev_class_q == CL_DIGIT && byte_s1 == CH_DOT && !dot_seen_q) ||
						(prev_class_q == CL_LETTER && cl == CL_DIGIT) ||
						(prev_class_q == CL_DIGIT && prev_byte_q == CH_ZERO &&
							pend_cnt_q == 2'd1 && (byte_s1 == CH_X || byte_s1 == CH_B)) ||
						(radix_q == RADIX_HEX && cl == CL_LETTER);
					if (!keep && pend_cnt_q != 2'd0 && prev_class_q != cl) begin
						res_c[n_c].ev = EV_EMIT;
						res_c[n_c].data = 8'd0;
						if (prev_class_q == CL_DIGIT)
							res_c[n_c].ttype = (radix_q == RADIX_DEC) ? TT_DEC :
								(radix_q == RADIX_BIN) ? TT_BIN :
								(radix_q == RADIX_HEX) ? TT_HEX : TT_WORD;
						else if (prev_class_q == CL_JOIN)
							res_c[n_c].ttype = TT_OPERATOR;
						else if (prev_class_q == CL_SEMI)
							res_c[n_c].ttype = TT_BREAKER;
						else
							res_c[n_c].ttype = TT_WORD;
						n_c = n_c + 2'd1;
						nx_radix = RADIX_DEC;
						nx_dot_seen = 1'b0;
						nx_pend_cnt = 2'd0;
					end
				end
				case (cl)
					CL_LETTER: begin
						if (prev_class_q == CL_DIGIT && prev_byte_q == CH_ZERO &&
							nx_pend_cnt == 2'd1 && (byte_s1 == CH_X || byte_s1 == CH_B)) begin
							// Radix prefix: the letter sets the radix and is not kept.
							nx_radix = (byte_s1 == CH_X) ? RADIX_HEX : RADIX_BIN;
							ecl = CL_DIGIT;
						end else begin
							if (nx_pend_cnt != 2'd2) nx_pend_cnt = nx_pend_cnt + 2'd1;
							res_c[n_c] = '{ev: EV_APPEND, data: byte_s1, ttype: TT_WORD};
							n_c = n_c + 2'd1;
						end
						if (nx_radix == RADIX_HEX && is_hex_letter(byte_s1)) ecl = CL_DIGIT;
					end
					CL_DIGIT: begin
						if (prev_class_q == CL_JOIN && nx_pend_cnt == 2'd1 &&
							prev_byte_q == CH_DOT && !nx_dot_seen)
							nx_dot_seen = 1'b1;
						if (prev_class_q == CL_LETTER) ecl = CL_LETTER;
						// A digit that is not binary closes a binary number as decimal.
						if (nx_radix == RADIX_BIN && byte_s1 != CH_ZERO && byte_s1 != CH_ONE) begin
							res_c[n_c] = '{ev: EV_EMIT, data: 8'd0, ttype: TT_DEC};
							n_c = n_c + 2'd1;
							nx_radix = RADIX_DEC;
							nx_pend_cnt = 2'd0;
						end
						if (nx_pend_cnt != 2'd2) nx_pend_cnt = nx_pend_cnt + 2'd1;
						res_c[n_c] = '{ev: EV_APPEND, data: byte_s1, ttype: TT_WORD};
						n_c = n_c + 2'd1;
					end
					CL_JOIN: begin
						if (prev_byte_q == CH_SLASH &&
							(byte_s1 == CH_SLASH || byte_s1 == CH_STAR)) begin
							// Comment start: drop the pending token, keep previous byte.
							nx_mode = MODE_COMMENT;
							nx_block_cmt = (byte_s1 == CH_STAR);
							nx_pend_cnt = 2'd0;
							res_c[n_c] = '{ev: EV_DROP, data: 8'd0, ttype: TT_WORD};
							n_c = n_c + 2'd1;
							early = 1'b1;
						end else begin
							if (nx_pend_cnt != 2'd2) nx_pend_cnt = nx_pend_cnt + 2'd1;
							res_c[n_c] = '{ev: EV_APPEND, data: byte_s1, ttype: TT_WORD};
							n_c = n_c + 2'd1;
							if (byte_s1 == CH_DOT && !nx_dot_seen && prev_class_q == CL_DIGIT &&
								nx_pend_cnt != 2'd1) begin
								nx_dot_seen = 1'b1;
								ecl = CL_DIGIT;
							end
						end
					end
					CL_PUNCT: begin
						res_c[n_c] = '{ev: EV_SINGLE, data: byte_s1, ttype: TT_PUNCT};
						n_c = n_c + 2'd1;
						nx_pend_cnt = 2'd0;
					end
					CL_SEMI: begin
						if (nx_pend_cnt != 2'd2) nx_pend_cnt = nx_pend_cnt + 2'd1;
						res_c[n_c] = '{ev: EV_APPEND, data: byte_s1, ttype: TT_WORD};
						n_c = n_c + 2'd1;
					end
					CL_DQ, CL_SQ: begin
						nx_mode = MODE_STRING;
						nx_quote_single = (cl == CL_SQ);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		// Newlines and comment openers never touch the history; any other byte equal to the end byte closes the stream.
		if (!early && cl != CL_NL) begin
			if (byte_s1 == end_byte_q) begin
				res_c[n_c] = '{ev: EV_END, data: byte_s1, ttype: TT_WORD};
				n_c = n_c + 2'd1;
				nx_mode = MODE_NORMAL;
				nx_prev_byte = 8'd0;
				nx_prev_class = CL_NULL;
				nx_pend_cnt = 2'd0;
				nx_quote_single = 1'b0;
				nx_radix = RADIX_DEC;
				nx_dot_seen = 1'b0;
				nx_block_cmt = 1'b0;
				nx_started = 1'b0;
			end else begin
				nx_prev_byte = byte_s1;
				nx_prev_class = ecl;
				nx_started = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_byte_q <= 8'd0;
		end else if (cfg_we) begin
			end_byte_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Scan state advances when the byte moves into the result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			prev_byte_q <= 8'd0;
			prev_class_q <= CL_NULL;
			pend_cnt_q <= 2'd0;
			quote_single_q <= 1'b0;
			radix_q <= RADIX_DEC;
			dot_seen_q <= 1'b0;
			block_cmt_q <= 1'b0;
			started_q <= 1'b0;
		end else if (load) begin
			mode_q <= nx_mode;
			prev_byte_q <= nx_prev_byte;
			prev_class_q <= nx_prev_class;
			pend_cnt_q <= nx_pend_cnt;
			quote_single_q <= nx_quote_single;
			radix_q <= nx_radix;
			dot_seen_q <= nx_dot_seen;
			block_cmt_q <= nx_block_cmt;
			started_q <= nx_started;
		end
	end

	// Result buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= n_c;
			idx_q <= 2'd0;
		end else if (take) begin
			if (idx_q + 2'd1 == cnt_q) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q[0] <= res_c[0];
			res_q[1] <= res_c[1];
			res_q[2] <= res_c[2];
		end
	end

	always_comb begin
		case (idx_q)
			2'd0:    out_res = res_q[0];
			2'd1:    out_res = res_q[1];
			default: out_res = res_q[2];
		endcase
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = out_res.data;
	assign m_axis_tuser  = {out_res.ttype, out_res.ev};
	assign m_axis_tlast  = (idx_q + 2'd1 == cnt_q);

`ifndef SYNTHESIS
	// The read index always points inside the loaded entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (idx_q < cnt_q))
		else $error("result read index beyond loaded entries");

	// A drop event is always the final beat of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2:0] == EV_DROP) |-> m_axis_tlast)
		else $error("drop event not marked last");

	// An end event is always the final beat of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2:0] == EV_END) |-> m_axis_tlast)
		else $error("end event not marked last");

	// Nothing is pending while a comment is skipped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_COMMENT) |-> (pend_cnt_q == 2'd0))
		else $error("pending count nonzero in comment mode");

	// An end event leaves the scan state at its reset value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && n_c != 2'd0 && res_c[n_c - 2'd1].ev == EV_END) |=>
			(mode_q == MODE_NORMAL && !started_q && pend_cnt_q == 2'd0))
		else $error("scan state not cleared after end byte");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the script lexer token event unit.
`timescale 1ns / 1ps

module tb_top;
	import sltev_pkg::*;

	// Quote and blank characters used by the stimulus and the predictor.
	localparam logic [7:0] QUOTE_SQ = 8'h27;
	localparam logic [7:0] QUOTE_DQ = 8'h22;
	localparam logic [7:0] BLANK    = 8'h20;

	// One expected result beat: event code, byte, token type and the tlast flag.
	typedef struct {
		logic [2:0] ev;
		logic [7:0] data;
		logic [3:0] ttype;
		logic       last;
	} lex_event_t;

	// The scoreboard keeps its own copy of the scan state and of the end byte
	// register. Every accepted source byte is run through the lexer rules and
	// the events it causes are queued; every result beat is checked against
	// the oldest queued event.
	class lexer_scoreboard;
		lex_event_t  event_fifo[$];
		lex_event_t  batch[$];
		int          errors;
		logic [7:0]  stop_byte;
		mode_t       mode;
		logic [7:0]  last_byte;
		class_t      last_class;
		logic [1:0]  run_len;
		bit          single_quote;
		logic [1:0]  radix;
		bit          dot_flag;
		bit          in_block;
		bit          seen_any;

		function new();
			errors = 0;
			stop_byte = 8'h00;
			clear_scan();
		endfunction

		function void clear_scan();
			mode = MODE_NORMAL;
			last_byte = 8'h00;
			last_class = CL_NULL;
			run_len = 2'd0;
			single_quote = 1'b0;
			radix = RADIX_DEC;
			dot_flag = 1'b0;
			in_block = 1'b0;
			seen_any = 1'b0;
		endfunction

		function void set_stop_byte(input logic [7:0] v);
			stop_byte = v;
		endfunction

		function int waiting();
			return event_fifo.size();
		endfunction

		function class_t byte_kind(input logic [7:0] c);
			if (c == 8'h00 || c == 8'hFF) return CL_NULL;
			if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CL_LETTER;
			if (c >= "0" && c <= "9") return CL_DIGIT;
			if (c == QUOTE_DQ) return CL_DQ;
			if (c == QUOTE_SQ) return CL_SQ;
			if (c == "*" || c == "/" || c == "+" || c == "=" || c == "^" ||
				c == "<" || c == ">" || c == ".") return CL_JOIN;
			if (c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
				c == "}" || c == "-" || c == "," || c == ":" || c == "@") return CL_PUNCT;
			if (c == BLANK || c == 8'h09) return CL_SPACE;
			if (c == CH_BSL) return CL_BSL;
			if (c == CH_NL) return CL_NL;
			if (c == CH_SEMI) return CL_SEMI;
			return CL_OTHER;
		endfunction

		// Type of the token that is pending, judged by the class of its last byte.
		function logic [3:0] run_type();
			if (last_class == CL_DIGIT) begin
				if (radix == RADIX_DEC) return TT_DEC;
				if (radix == RADIX_BIN) return TT_BIN;
				if (radix == RADIX_HEX) return TT_HEX;
				return TT_WORD;
			end
			if (last_class == CL_JOIN) return TT_OPERATOR;
			if (last_class == CL_SEMI) return TT_BREAKER;
			return TT_WORD;
		endfunction

		function void post(input logic [2:0] ev, input logic [7:0] d, input logic [3:0] tt);
			lex_event_t e;
			e.ev = ev;
			e.data = d;
			e.ttype = tt;
			e.last = 1'b0;
			batch.push_back(e);
		endfunction

		function void extend_run(input logic [7:0] c);
			if (run_len < 2'd2) run_len++;
			post(EV_APPEND, c, TT_WORD);
		endfunction

		// Applies one accepted source byte; returns how many events it causes.
		function int note_byte(input logic [7:0] c);
			class_t cl;
			class_t next_class;
			bit     closes;
			bit     keep;
			bit     opened;
			cl = byte_kind(c);
			next_class = cl;
			opened = 1'b0;
			batch.delete();
			if (mode == MODE_STRING) begin
				closes = (cl == CL_DQ && !single_quote) || (cl == CL_SQ && single_quote);
				if (closes) begin
					post(EV_EMIT, 8'h00, single_quote ? TT_SQ_STR : TT_DQ_STR);
					mode = MODE_NORMAL;
					run_len = 2'd0;
					single_quote = 1'b0;
				end else if (cl == CL_DQ || cl == CL_SQ || cl == CL_LETTER || cl == CL_DIGIT ||
					cl == CL_JOIN || cl == CL_PUNCT || cl == CL_SPACE) begin
					extend_run(c);
				end
			end else if (mode == MODE_COMMENT) begin
				if ((c == CH_NL && !in_block) || (last_byte == CH_STAR && c == CH_SLASH && in_block)) begin
					mode = MODE_NORMAL;
					in_block = 1'b0;
				end
			end else begin
				if (seen_any) begin
					// Number continuations keep the pending token open across a class change.
					keep = (last_class == CL_JOIN && last_byte == CH_DOT && run_len == 2'd1 &&
							cl == CL_DIGIT && !dot_flag) ||
						(last_class == CL_DIGIT && c == CH_DOT && !dot_flag) ||
						(last_class == CL_LETTER && cl == CL_DIGIT) ||
						(last_class == CL_DIGIT && last_byte == CH_ZERO && run_len == 2'd1 &&
							cl == CL_LETTER && (c == CH_X || c == CH_B)) ||
						(radix == RADIX_HEX && cl == CL_LETTER);
					if (!keep && run_len != 2'd0 && last_class != cl) begin
						post(EV_EMIT, 8'h00, run_type());
						radix = RADIX_DEC;
						dot_flag = 1'b0;
						run_len = 2'd0;
					end
				end
				case (cl)
					CL_LETTER: begin
						if (last_class == CL_DIGIT && last_byte == CH_ZERO && run_len == 2'd1 &&
							(c == CH_X || c == CH_B)) begin
							radix = (c == CH_X) ? RADIX_HEX : RADIX_BIN;
							next_class = CL_DIGIT;
						end else begin
							extend_run(c);
						end
						if (radix == RADIX_HEX &&
							((c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
							next_class = CL_DIGIT;
					end
					CL_DIGIT: begin
						if (last_class == CL_JOIN && run_len == 2'd1 && last_byte == CH_DOT && !dot_flag)
							dot_flag = 1'b1;
						if (last_class == CL_LETTER)
							next_class = CL_LETTER;
						// A digit above 1 breaks a binary number: flush it as decimal.
						if (radix == RADIX_BIN && c != CH_ZERO && c != CH_ONE) begin
							post(EV_EMIT, 8'h00, TT_DEC);
							radix = RADIX_DEC;
							run_len = 2'd0;
						end
						extend_run(c);
					end
					CL_JOIN: begin
						if (last_byte == CH_SLASH && (c == CH_SLASH || c == CH_STAR)) begin
							mode = MODE_COMMENT;
							in_block = (c == CH_STAR);
							run_len = 2'd0;
							post(EV_DROP, 8'h00, TT_WORD);
							opened = 1'b1;
						end else begin
							extend_run(c);
							if (c == CH_DOT && !dot_flag && last_class == CL_DIGIT && run_len != 2'd1) begin
								dot_flag = 1'b1;
								next_class = CL_DIGIT;
							end
						end
					end
					CL_PUNCT: begin
						post(EV_SINGLE, c, TT_PUNCT);
						run_len = 2'd0;
					end
					CL_SEMI: extend_run(c);
					CL_DQ, CL_SQ: begin
						mode = MODE_STRING;
						single_quote = (cl == CL_SQ);
					end
					default: ;
				endcase
			end
			// A comment opener keeps the previous byte; a newline never touches it.
			if (!opened && cl != CL_NL) begin
				if (c == stop_byte) begin
					post(EV_END, c, TT_WORD);
					clear_scan();
				end else begin
					last_byte = c;
					last_class = next_class;
					seen_any = 1'b1;
				end
			end
			if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) event_fifo.push_back(batch[i]);
			return batch.size();
		endfunction

		task report(input string what);
			errors++;
			if (errors <= 50) $display("ERROR at %0t ns: %s", $time, what);
		endtask

		task check_beat(input logic [7:0] d, input logic [6:0] u, input logic l);
			lex_event_t e;
			if (event_fifo.size() == 0) begin
				report($sformatf("unexpected beat ev=%0d data=%02h type=%0d last=%0b",
					u[2:0], d, u[6:3], l));
			end else begin
				e = event_fifo.pop_front();
				if (u[2:0] !== e.ev || d !== e.data || u[6:3] !== e.ttype || l !== e.last)
					report($sformatf("expected ev=%0d data=%02h type=%0d last=%0b, got ev=%0d data=%02h type=%0d last=%0b",
						e.ev, e.data, e.ttype, e.last, u[2:0], d, u[6:3], l));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [6:0] m_axis_tuser;
	logic       m_axis_tlast;

	lexer_scoreboard sb;
	bit         idle_on = 1'b1;    // random gaps and stalls allowed
	int         stall_left = 0;    // remaining cycles of the current sink stall
	int         sent = 0;          // source bytes accepted in the current phase
	logic [7:0] cur_end = 8'h00;   // end byte value currently programmed

	script_lexer_token_events_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs; the slowest correct run needs well
	// under a tenth of this.
	initial begin
		#5_000_000;
		$display("script_lexer_token_events_unit verification failed");
		$finish;
	end

	// Result side. Beats are checked with the values seen at the edge, and
	// tready is stalled in random bursts while idling is on.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= (stall_left == 0);
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Offers one source byte, with an occasional gap before it, and waits for
	// the beat to be taken. The predictor sees the byte once it is accepted.
	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		void'(sb.note_byte(b));
		sent++;
	endtask

	// Lets the block drain. Bytes that cause no events can still be inside the
	// two-stage pipe when the queue empties, so the task goes on waiting to let them out.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_end_byte(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_stop_byte(v);
		cur_end = v;
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25)) :
			8'(8'h41 + $urandom_range(0, 25));
	endfunction

	// Sends one lexeme-shaped sequence with random content. Most choices are
	// well-formed tokens, strings and comments; the rest is blanks, raw noise
	// and the end byte.
	task automatic emit_token();
		int         kind;
		logic [7:0] q;
		logic [7:0] ch;
		kind = $urandom_range(0, 15);
		case (kind)
			0, 1, 2: begin
				repeat ($urandom_range(1, 5)) send_byte(rand_letter());
				repeat ($urandom_range(0, 2)) send_byte(pick("0123456789"));
			end
			3, 4: begin
				if ($urandom_range(0, 3) == 0) send_byte(CH_DOT);
				repeat ($urandom_range(1, 4)) send_byte(pick("0123456789"));
				if ($urandom_range(0, 1)) begin
					send_byte(CH_DOT);
					repeat ($urandom_range(0, 2)) send_byte(pick("0123456789"));
				end
			end
			5: begin
				send_byte(CH_ZERO);
				send_byte(CH_X);
				repeat ($urandom_range(1, 4)) send_byte(pick("0123456789abcdefABCDEFgz"));
			end
			6: begin
				send_byte(CH_ZERO);
				send_byte(CH_B);
				repeat ($urandom_range(1, 4)) send_byte(pick("0101010129"));
			end
			7: repeat ($urandom_range(1, 3)) send_byte(pick("*+=^<>./"));
			8: send_byte(pick("()[]{}-,:@"));
			9: send_byte(CH_SEMI);
			10: begin
				q = $urandom_range(0, 1) ? QUOTE_SQ : QUOTE_DQ;
				send_byte(q);
				repeat ($urandom_range(0, 5)) begin
					ch = pick("aZ09+(. \\#\"'\t");
					send_byte((ch == q) ? BLANK : ch);
				end
				send_byte(q);
			end
			11: begin
				send_byte(CH_SLASH);
				send_byte(CH_SLASH);
				repeat ($urandom_range(0, 4)) send_byte(pick("a*/ 1;\"x"));
				send_byte(CH_NL);
			end
			12: begin
				send_byte(CH_SLASH);
				send_byte(CH_STAR);
				repeat ($urandom_range(0, 4)) send_byte(pick("a*/ 1;\n'"));
				send_byte(CH_STAR);
				send_byte(CH_SLASH);
			end
			13: send_byte(pick(" \t\n"));
			14: send_byte(8'($urandom_range(0, 255)));
			default: send_byte(cur_end);
		endcase
		if ($urandom_range(0, 2) == 0) send_byte(BLANK);
	endtask

	task automatic random_phase(input logic [7:0] end_value, input int target);
		write_end_byte(end_value);
		sent = 0;
		while (sent < target) emit_token();
		settle();
	endtask

	initial begin
		string opening;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the end byte at zero: a binary number cut by a bad
		// digit, a fraction, an operator, a word with a digit, a block comment,
		// a single-quoted string holding a double quote, a line comment,
		// punctuation, a breaker, a backslash, an unknown byte, the 8'hFF null byte
		// and finally the end byte itself, which is the other null byte.
		write_end_byte(8'h00);
		opening = "0b12.5+a1/**/'\"'//\n(;\\#";
		for (int i = 0; i < opening.len(); i++) send_byte(opening[i]);
		send_byte(8'hFF);
		send_byte(8'h00);
		settle();

		// Random phases under several end bytes: the top value, the breaker,
		// the newline (which never ends the stream) and random values.
		random_phase(8'hFF, 27);
		random_phase(CH_SEMI, 27);
		random_phase(CH_NL, 27);
		random_phase(8'($urandom_range(0, 255)), 27);

		// The closing stretch runs without gaps or stalls.
		idle_on = 1'b0;
		random_phase(8'($urandom_range(0, 255)), 27);

		if (sb.errors == 0) begin
			$display("script_lexer_token_events_unit verification clean");
		end else begin
			$display("script_lexer_token_events_unit verification failed");
		end
		$finish;
	end

endmodule
